// ===== src/lrsr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrsr_pkg
// Shared constants and types of the LR shift-reduce parse engine.
// ----------------------------------------------------------------------------
package lrsr_pkg;

    localparam int NUM_STATES  = 64;
    localparam int NUM_SYMBOLS = 32;
    localparam int NUM_RULES   = 64;
    localparam int STACK_DEPTH = 64;
    localparam int REDUCE_LIMIT = 4096;

    localparam int TBL_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int RULE_AW   = $clog2(NUM_RULES);
    localparam int STK_AW    = $clog2(STACK_DEPTH);
    localparam int SP_W      = $clog2(STACK_DEPTH + 1);
    localparam int CLR_W     = TBL_AW + 1;

    localparam logic [2:0] CMD_TOKEN   = 3'd0;
    localparam logic [2:0] CMD_ACTION  = 3'd1;
    localparam logic [2:0] CMD_GOTO    = 3'd2;
    localparam logic [2:0] CMD_RULE    = 3'd3;
    localparam logic [2:0] CMD_RESTART = 3'd4;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_SHIFT  = 2'd1;
    localparam logic [1:0] ACT_REDUCE = 2'd2;
    localparam logic [1:0] ACT_ACCEPT = 2'd3;

    localparam logic [2:0] ST_SHIFTED   = 3'd0;
    localparam logic [2:0] ST_ACCEPTED  = 3'd1;
    localparam logic [2:0] ST_NOACTION  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;
    localparam logic [2:0] ST_WRITTEN   = 3'd5;
    localparam logic [2:0] ST_REJECTED  = 3'd6;

    localparam logic [1:0] FIN_RUN    = 2'd0;
    localparam logic [1:0] FIN_ACCEPT = 2'd1;
    localparam logic [1:0] FIN_FAIL   = 2'd2;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] reductions;
        logic [5:0] top_state;
        logic [5:0] last_rule;
    } t_result;

endpackage

// ===== src/lrsr_ram.sv =====
// ----------------------------------------------------------------------------
// lrsr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lrsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lr_shift_reduce_parse_engine.sv =====
// ----------------------------------------------------------------------------
// lr_shift_reduce_parse_engine
// Table-driven LR parser driver with action, goto, rule and stack memories.
// ----------------------------------------------------------------------------
// A table write or restart goes through S_DONE and S_OUT before its result is valid.
// A token goes through S_ACTRD, S_ACTEV, S_DONE and S_OUT; each reduction adds S_RULEV,
// S_STKEV, S_GOTEV and another S_ACTRD/S_ACTEV pass, and reads the action memory, the rule
// memory, the stack memory and the goto memory in turn. One item is processed at a time;
// the next is accepted once the result is taken. After reset the action memory is cleared,
// one entry a cycle, all 2048 entries, during which no item is accepted.
module lr_shift_reduce_parse_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd, symbol, state_id, action_kind, target, rule_id, rule_length,
    // rule_left from bit 0 up, zero-filled to 40 bits.
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, reductions, top_state, last_rule from bit 0 up, zero-filled.
    output logic [23:0] m_axis_tdata
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ACTRD  = 4'd2;
    localparam logic [3:0] S_ACTEV  = 4'd3;
    localparam logic [3:0] S_RULEV  = 4'd4;
    localparam logic [3:0] S_STKEV  = 4'd5;
    localparam logic [3:0] S_GOTEV  = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    localparam int SW = lrsr_pkg::STK_AW;

    logic [3:0]  r_state, n_state;
    logic [lrsr_pkg::CLR_W-1:0] r_clr;
    logic [5:0]  r_start;
    logic [lrsr_pkg::SP_W-1:0] r_sp, n_sp;
    logic [5:0]  r_top, n_top;
    logic [1:0]  r_fin, n_fin;
    logic [4:0]  r_sym;
    logic [12:0] r_steps, n_steps;
    logic [5:0]  r_rule, n_rule;
    logic [5:0]  r_cnt, n_cnt;
    logic [lrsr_pkg::SP_W-1:0] r_base, n_base;
    logic [4:0]  r_left, n_left;
    logic        r_ovalid, n_ovalid;
    lrsr_pkg::t_result r_res, n_res;

    logic [2:0] in_cmd;
    logic [4:0] in_sym;
    logic [5:0] in_row, in_tgt, in_rid;
    logic [1:0] in_kind;
    logic [3:0] in_len;
    logic [4:0] in_left;
    logic       in_acc;

    assign in_cmd  = s_axis_tdata[2:0];
    assign in_sym  = s_axis_tdata[7:3];
    assign in_row  = s_axis_tdata[13:8];
    assign in_kind = s_axis_tdata[15:14];
    assign in_tgt  = s_axis_tdata[21:16];
    assign in_rid  = s_axis_tdata[27:22];
    assign in_len  = s_axis_tdata[31:28];
    assign in_left = s_axis_tdata[36:32];

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, r_res.last_rule, r_res.top_state,
                            r_res.reductions, r_res.status};

    // Memory ports.
    logic                      act_we, got_we, rul_we, stk_we;
    logic [lrsr_pkg::TBL_AW-1:0] act_wa, act_ra, got_wa, got_ra;
    logic [7:0]  act_wd, act_rd;
    logic [5:0]  got_wd, got_rd;
    logic [lrsr_pkg::RULE_AW-1:0] rul_wa, rul_ra;
    logic [8:0]  rul_wd, rul_rd;
    logic [SW-1:0] stk_wa, stk_ra;
    logic [5:0]  stk_wd, stk_rd;

    lrsr_ram #(.WIDTH(8), .DEPTH(lrsr_pkg::TBL_DEPTH)) u_act (
        .i_clk(i_clk), .i_we(act_we), .i_waddr(act_wa), .i_wdata(act_wd),
        .i_raddr(act_ra), .o_rdata(act_rd));
    lrsr_ram #(.WIDTH(6), .DEPTH(lrsr_pkg::TBL_DEPTH)) u_goto (
        .i_clk(i_clk), .i_we(got_we), .i_waddr(got_wa), .i_wdata(got_wd),
        .i_raddr(got_ra), .o_rdata(got_rd));
    lrsr_ram #(.WIDTH(9), .DEPTH(lrsr_pkg::NUM_RULES)) u_rule (
        .i_clk(i_clk), .i_we(rul_we), .i_waddr(rul_wa), .i_wdata(rul_wd),
        .i_raddr(rul_ra), .o_rdata(rul_rd));
    lrsr_ram #(.WIDTH(6), .DEPTH(lrsr_pkg::STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd));

    logic [1:0] a_kind;
    logic [5:0] a_tgt;
    logic [3:0] r_len_f;
    logic [4:0] r_left_f;
    assign a_kind   = act_rd[7:6];
    assign a_tgt    = act_rd[5:0];
    assign r_len_f  = rul_rd[8:5];
    assign r_left_f = rul_rd[4:0];

    always_comb begin
        n_state  = r_state;
        n_sp     = r_sp;
        n_top    = r_top;
        n_fin    = r_fin;
        n_steps  = r_steps;
        n_rule   = r_rule;
        n_cnt    = r_cnt;
        n_base   = r_base;
        n_left   = r_left;
        n_ovalid = r_ovalid;
        n_res    = r_res;
        act_we = 1'b0;
        act_wa = {r_top[$clog2(lrsr_pkg::NUM_STATES)-1:0], r_sym};
        act_wd = 8'd0;
        act_ra = {r_top, r_sym};
        got_we = 1'b0;
        got_wa = {in_row, in_sym};
        got_wd = in_tgt;
        got_ra = {stk_rd, r_left};
        rul_we = 1'b0;
        rul_wa = in_rid;
        rul_wd = {in_len, in_left};
        rul_ra = r_rule;
        stk_we = 1'b0;
        stk_wa = r_sp[SW-1:0];
        stk_wd = r_top;
        stk_ra = r_sp[SW-1:0];

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                act_we = 1'b1;
                act_wa = r_clr[lrsr_pkg::TBL_AW-1:0];
                act_wd = 8'd0;
                stk_we = 1'b1;
                stk_wa = '0;
                stk_wd = 6'd0;
                if (r_clr == lrsr_pkg::CLR_W'(lrsr_pkg::TBL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_cnt  = 6'd0;
                    n_rule = 6'd0;
                    n_res.reductions = 6'd0;
                    n_res.last_rule  = 6'd0;
                    n_res.top_state  = r_top;
                    n_state = S_DONE;
                    case (in_cmd)
                        lrsr_pkg::CMD_TOKEN: begin
                            if (r_fin != lrsr_pkg::FIN_RUN) begin
                                n_res.status = lrsr_pkg::ST_REJECTED;
                            end else begin
                                n_steps = 13'd0;
                                n_state = S_ACTRD;
                            end
                        end
                        lrsr_pkg::CMD_ACTION: begin
                            act_we = 1'b1;
                            act_wa = {in_row, in_sym};
                            act_wd = {in_kind, in_tgt};
                            n_res.status = lrsr_pkg::ST_WRITTEN;
                        end
                        lrsr_pkg::CMD_GOTO: begin
                            got_we = 1'b1;
                            n_res.status = lrsr_pkg::ST_WRITTEN;
                        end
                        lrsr_pkg::CMD_RULE: begin
                            rul_we = 1'b1;
                            n_res.status = lrsr_pkg::ST_WRITTEN;
                        end
                        lrsr_pkg::CMD_RESTART: begin
                            stk_we = 1'b1;
                            stk_wa = '0;
                            stk_wd = r_start;
                            n_sp   = lrsr_pkg::SP_W'(1);
                            n_top  = r_start;
                            n_fin  = lrsr_pkg::FIN_RUN;
                            n_res.top_state = r_start;
                            n_res.status = lrsr_pkg::ST_WRITTEN;
                        end
                        default: begin
                            n_res.status = lrsr_pkg::ST_REJECTED;
                        end
                    endcase
                end
            end
            S_ACTRD: begin
                act_ra = {r_top, r_sym};
                n_state = S_ACTEV;
            end
            S_ACTEV: begin
                n_state = S_DONE;
                n_fin = lrsr_pkg::FIN_FAIL;
                case (a_kind)
                    lrsr_pkg::ACT_NONE: n_res.status = lrsr_pkg::ST_NOACTION;
                    lrsr_pkg::ACT_ACCEPT: begin
                        n_res.status = lrsr_pkg::ST_ACCEPTED;
                        n_fin = lrsr_pkg::FIN_ACCEPT;
                    end
                    lrsr_pkg::ACT_SHIFT: begin
                        if (r_sp >= lrsr_pkg::SP_W'(lrsr_pkg::STACK_DEPTH)) begin
                            n_res.status = lrsr_pkg::ST_OVERFLOW;
                        end else begin
                            stk_we = 1'b1;
                            stk_wa = r_sp[SW-1:0];
                            stk_wd = a_tgt;
                            n_sp   = r_sp + 1'b1;
                            n_top  = a_tgt;
                            n_fin  = lrsr_pkg::FIN_RUN;
                            n_res.status = lrsr_pkg::ST_SHIFTED;
                        end
                    end
                    default: begin
                        if (r_steps >= 13'(lrsr_pkg::REDUCE_LIMIT)) begin
                            n_res.status = lrsr_pkg::ST_NOACTION;
                        end else begin
                            rul_ra  = a_tgt;
                            n_rule  = a_tgt;
                            n_fin   = r_fin;
                            n_state = S_RULEV;
                        end
                    end
                endcase
            end
            S_RULEV: begin
                n_left = r_left_f;
                n_base = r_sp - lrsr_pkg::SP_W'(r_len_f);
                stk_ra = SW'(r_sp - lrsr_pkg::SP_W'(r_len_f) - 1'b1);
                if (lrsr_pkg::SP_W'(r_len_f) >= r_sp) begin
                    n_res.status = lrsr_pkg::ST_UNDERFLOW;
                    n_fin = lrsr_pkg::FIN_FAIL;
                    n_state = S_DONE;
                end else if (n_base >= lrsr_pkg::SP_W'(lrsr_pkg::STACK_DEPTH)) begin
                    n_res.status = lrsr_pkg::ST_OVERFLOW;
                    n_fin = lrsr_pkg::FIN_FAIL;
                    n_state = S_DONE;
                end else begin
                    n_state = S_STKEV;
                end
            end
            S_STKEV: begin
                got_ra = {stk_rd, r_left};
                n_state = S_GOTEV;
            end
            S_GOTEV: begin
                stk_we = 1'b1;
                stk_wa = r_base[SW-1:0];
                stk_wd = got_rd;
                n_sp   = r_base + 1'b1;
                n_top  = got_rd;
                n_steps = r_steps + 1'b1;
                if (r_cnt != 6'd63) begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_res.last_rule = r_rule;
                n_state = S_ACTRD;
            end
            S_DONE: begin
                n_res.reductions = r_cnt;
                n_res.top_state  = r_top;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_start  <= 6'd0;
            r_sp     <= lrsr_pkg::SP_W'(1);
            r_top    <= 6'd0;
            r_fin    <= lrsr_pkg::FIN_RUN;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= r_clr + 1'b1;
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
            r_sp     <= n_sp;
            r_top    <= n_top;
            r_fin    <= n_fin;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sym <= in_sym;
        end
        r_steps <= n_steps;
        r_rule  <= n_rule;
        r_cnt   <= n_cnt;
        r_base  <= n_base;
        r_left  <= n_left;
        r_res   <= n_res;
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the LR shift-reduce parse engine against a cycle-free predictor.
// Every item sent on the input stream is run through the predictor, and each
// result on the output stream is compared field by field with the oldest
// outstanding prediction. The run loads every rule and the goto entries that
// the generated grammars can reach, then drives directed items and random
// grammars under several idle and stall mixes, including one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 100000000;

    class parse_scoreboard;
        bit [7:0] action_mem[lrsr_pkg::TBL_DEPTH];
        bit [5:0] goto_mem[lrsr_pkg::TBL_DEPTH];
        bit [8:0] rule_mem[lrsr_pkg::NUM_RULES];
        bit [5:0] stack_mem[lrsr_pkg::STACK_DEPTH];
        int unsigned depth;
        bit [1:0] finished;
        bit [5:0] start_state;
        lrsr_pkg::t_result pending[$];
        int errors;

        function void restart();
            stack_mem[0] = start_state;
            depth = 1;
            finished = lrsr_pkg::FIN_RUN;
        endfunction

        function bit [5:0] top();
            if (depth == 0 || depth > lrsr_pkg::STACK_DEPTH) return 0;
            return stack_mem[depth - 1];
        endfunction

        function bit [2:0] parse_token(bit [4:0] sym, ref bit [5:0] cnt,
                                       ref bit [5:0] last);
            int unsigned steps;
            int unsigned base;
            bit [7:0] ent;
            bit [5:0] st;
            bit [5:0] tgt;
            bit [8:0] rec;
            steps = 0;
            forever begin
                st = top();
                ent = action_mem[st * lrsr_pkg::NUM_SYMBOLS + sym];
                tgt = ent[5:0];
                case (ent[7:6])
                    lrsr_pkg::ACT_NONE: return lrsr_pkg::ST_NOACTION;
                    lrsr_pkg::ACT_ACCEPT: return lrsr_pkg::ST_ACCEPTED;
                    lrsr_pkg::ACT_SHIFT: begin
                        if (depth >= lrsr_pkg::STACK_DEPTH) return lrsr_pkg::ST_OVERFLOW;
                        stack_mem[depth] = tgt;
                        depth++;
                        return lrsr_pkg::ST_SHIFTED;
                    end
                    default: begin
                        if (steps >= lrsr_pkg::REDUCE_LIMIT) return lrsr_pkg::ST_NOACTION;
                        rec = rule_mem[tgt];
                        if (rec[8:5] >= depth) return lrsr_pkg::ST_UNDERFLOW;
                        base = depth - rec[8:5];
                        if (base >= lrsr_pkg::STACK_DEPTH) return lrsr_pkg::ST_OVERFLOW;
                        st = stack_mem[base - 1];
                        stack_mem[base] = goto_mem[st * lrsr_pkg::NUM_SYMBOLS + rec[4:0]];
                        depth = base + 1;
                        steps++;
                        if (cnt < 63) cnt++;
                        last = tgt;
                    end
                endcase
            end
        endfunction

        function void note_item(bit [39:0] d);
            lrsr_pkg::t_result r;
            bit [5:0] cnt;
            bit [5:0] last;
            bit [10:0] idx;
            cnt = 0;
            last = 0;
            idx = {d[13:8], d[7:3]};
            case (d[2:0])
                lrsr_pkg::CMD_TOKEN: begin
                    if (finished != lrsr_pkg::FIN_RUN) begin
                        r.status = lrsr_pkg::ST_REJECTED;
                    end else begin
                        r.status = parse_token(d[7:3], cnt, last);
                        if (r.status != lrsr_pkg::ST_SHIFTED)
                            finished = (r.status == lrsr_pkg::ST_ACCEPTED) ?
                                       lrsr_pkg::FIN_ACCEPT : lrsr_pkg::FIN_FAIL;
                    end
                end
                lrsr_pkg::CMD_ACTION: begin
                    action_mem[idx] = {d[15:14], d[21:16]};
                    r.status = lrsr_pkg::ST_WRITTEN;
                end
                lrsr_pkg::CMD_GOTO: begin
                    goto_mem[idx] = d[21:16];
                    r.status = lrsr_pkg::ST_WRITTEN;
                end
                lrsr_pkg::CMD_RULE: begin
                    rule_mem[d[27:22]] = {d[31:28], d[36:32]};
                    r.status = lrsr_pkg::ST_WRITTEN;
                end
                lrsr_pkg::CMD_RESTART: begin
                    restart();
                    r.status = lrsr_pkg::ST_WRITTEN;
                end
                default: r.status = lrsr_pkg::ST_REJECTED;
            endcase
            r.reductions = cnt;
            r.top_state = top();
            r.last_rule = last;
            pending = {pending, r};
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(bit [23:0] q);
            lrsr_pkg::t_result e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", q));
                return;
            end
            e = pending.pop_front();
            if (q[2:0] != e.status)
                report($sformatf("status %0d, want %0d", q[2:0], e.status));
            if (q[8:3] != e.reductions)
                report($sformatf("reductions %0d, want %0d", q[8:3], e.reductions));
            if (q[14:9] != e.top_state)
                report($sformatf("top_state %0d, want %0d", q[14:9], e.top_state));
            if (q[20:15] != e.last_rule)
                report($sformatf("last_rule %0d, want %0d", q[20:15], e.last_rule));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [5:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    parse_scoreboard sb = new();
    int  send_idle = 0;
    int  recv_stall = 0;
    bit  hold_request = 0;
    int  hold_left = 0;
    int  cycles = 0;

    lr_shift_reduce_parse_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if (hold_request && hold_left == 0) begin
            hold_left = 400;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom % 100) >= recv_stall;
        end
    end

    function automatic bit [39:0] pack_item(bit [2:0] cmd, bit [4:0] sym, bit [5:0] row,
                                            bit [1:0] kind, bit [5:0] tgt, bit [5:0] rid,
                                            bit [3:0] rlen, bit [4:0] rleft);
        return {3'b000, rleft, rlen, rid, tgt, kind, row, sym, cmd};
    endfunction

    function automatic bit [39:0] noise_fields();
        return {3'b000, 37'($urandom) ^ {5'($urandom), 32'($urandom)}};
    endfunction

    task send_item(bit [39:0] d);
        while (($urandom % 100) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(d);
    endtask

    task send_token(bit [4:0] sym);
        bit [39:0] d;
        d = noise_fields();
        d[2:0] = lrsr_pkg::CMD_TOKEN;
        d[7:3] = sym;
        send_item(d);
    endtask

    task send_cmd(bit [2:0] cmd);
        bit [39:0] d;
        d = noise_fields();
        d[2:0] = cmd;
        send_item(d);
    endtask

    task write_start(bit [5:0] v);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.start_state = v;
    endtask

    function automatic bit [1:0] pick_kind();
        int r;
        r = $urandom % 100;
        if (r < 50) return lrsr_pkg::ACT_SHIFT;
        if (r < 85) return lrsr_pkg::ACT_REDUCE;
        if (r < 95) return lrsr_pkg::ACT_ACCEPT;
        return lrsr_pkg::ACT_NONE;
    endfunction

    task write_rule_rand(bit [5:0] rid);
        bit [3:0] len;
        len = ($urandom % 20 == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
        send_item(pack_item(lrsr_pkg::CMD_RULE, 5'($urandom), 6'($urandom), 2'($urandom),
                            6'($urandom), rid, len, 5'($urandom_range(0, 7))));
    endtask

    task write_action_rand();
        send_item(pack_item(lrsr_pkg::CMD_ACTION, 5'($urandom_range(0, 7)),
                            6'($urandom_range(0, 15)), pick_kind(),
                            6'($urandom_range(0, 15)), 6'($urandom),
                            4'($urandom), 5'($urandom)));
    endtask

    task run_phase(int n);
        int r;
        repeat (24) write_action_rand();
        send_cmd(lrsr_pkg::CMD_RESTART);
        repeat (n) begin
            r = $urandom % 100;
            if (r < 9) begin
                send_cmd(lrsr_pkg::CMD_RESTART);
            end else if (r < 16) begin
                write_action_rand();
            end else if (r < 18) begin
                send_item(pack_item(lrsr_pkg::CMD_GOTO, 5'($urandom), 6'($urandom),
                                    2'($urandom), 6'($urandom_range(0, 15)), 6'($urandom),
                                    4'($urandom), 5'($urandom)));
            end else if (r < 19) begin
                write_rule_rand(6'($urandom));
            end else if (r < 20) begin
                send_cmd(3'($urandom_range(5, 7)));
            end else begin
                send_token(($urandom % 20 == 0) ? 5'($urandom) : 5'($urandom_range(0, 7)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < lrsr_pkg::NUM_RULES; i++) write_rule_rand(6'(i));
        for (int s = 0; s < 17; s++) begin
            for (int c = 0; c < 8; c++) begin
                send_item(pack_item(lrsr_pkg::CMD_GOTO, 5'(c),
                                    (s == 16) ? 6'd63 : 6'(s), 2'($urandom),
                                    ($urandom % 16 == 0) ? 6'd63 : 6'($urandom_range(0, 15)),
                                    6'($urandom), 4'($urandom), 5'($urandom)));
            end
        end
        send_item(pack_item(lrsr_pkg::CMD_RULE, 5'd0, 6'd0, lrsr_pkg::ACT_NONE, 6'd0,
                            6'd63, 4'd15, 5'd7));

        write_start(6'd63);
        send_cmd(lrsr_pkg::CMD_RESTART);
        send_token(5'd31);
        send_token(5'd0);
        send_cmd(3'd5);
        send_cmd(3'd6);
        send_cmd(3'd7);
        send_item(pack_item(lrsr_pkg::CMD_ACTION, 5'd31, 6'd63, lrsr_pkg::ACT_SHIFT, 6'd63,
                            6'd0, 4'd0, 5'd0));
        send_cmd(lrsr_pkg::CMD_RESTART);
        send_token(5'd31);
        send_item(pack_item(lrsr_pkg::CMD_ACTION, 5'd31, 6'd63, lrsr_pkg::ACT_ACCEPT, 6'd0,
                            6'd0, 4'd0, 5'd0));
        send_token(5'd31);
        send_token(5'd31);
        send_item(pack_item(lrsr_pkg::CMD_ACTION, 5'd0, 6'd63, lrsr_pkg::ACT_REDUCE, 6'd63,
                            6'd0, 4'd0, 5'd0));
        send_cmd(lrsr_pkg::CMD_RESTART);
        send_token(5'd0);
        send_item(pack_item(lrsr_pkg::CMD_ACTION, 5'd1, 6'd63, lrsr_pkg::ACT_SHIFT, 6'd63,
                            6'd0, 4'd0, 5'd0));
        send_cmd(lrsr_pkg::CMD_RESTART);
        repeat (64) send_token(5'd1);

        write_start(6'd0);
        run_phase(100);

        send_idle = 78;
        write_start(6'd5);
        run_phase(80);

        send_idle = 0;
        recv_stall = 78;
        write_start(6'($urandom_range(0, 15)));
        run_phase(80);

        recv_stall = 0;
        hold_request = 1;
        run_phase(40);

        send_idle = 22;
        recv_stall = 22;
        write_start(6'($urandom_range(0, 15)));
        run_phase(90);

        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
